FILE: sv/light_bar_pair_matcher_macros.svh
// ----------------------------------------------------------------------------
// Light bar pair matcher assertion macros
// Shared helpers for writing concurrent checks with one clock and reset.
// ----------------------------------------------------------------------------
`ifndef LIGHT_BAR_PAIR_MATCHER_MACROS_SVH
`define LIGHT_BAR_PAIR_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lbpm_pkg.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher package
// Types, constants and the arctangent table shared by the matcher modules.
// ----------------------------------------------------------------------------
package lbpm_pkg;

  localparam int unsigned CoordW   = 14;
  localparam int unsigned AngW     = 16;
  localparam int unsigned IdxW     = 5;
  localparam int unsigned ResultLimit = 16;
  localparam int unsigned KW       = 5;
  localparam int unsigned CordicIters = 15;
  localparam int unsigned CordicW  = 22;
  localparam int unsigned ZW       = 17;
  localparam int unsigned ItW      = 4;

  localparam logic [AngW-1:0] AngRight = 16'd23040;  // 90 degrees, Q8.8
  localparam logic [AngW-1:0] AngFlat  = 16'd46080;  // 180 degrees, Q8.8
  localparam logic [AngW-1:0] AngClamp = 16'd15360;  // 60 degrees sum, Q8.8

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [AngW-1:0]   ang_t;
  typedef logic [IdxW-1:0]   idx_t;

  // One bar record as it travels from the front end to the store.
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t len;
    ang_t   ang;
    logic   last;
  } bar_rec_t;

  // The stored part of a bar record.
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t len;
    ang_t   ang;
  } bar_ent_t;

  localparam int unsigned EntW = $bits(bar_ent_t);

  typedef enum logic [1:0] {
    F_IDLE,
    F_ITER,
    F_FIX,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_LOAD,
    B_SCAN_I,
    B_LATCH_I,
    B_SCAN_J,
    B_DIFF,
    B_MUL,
    B_CMP,
    B_DONE
  } back_state_e;

  // atan(2^-i) in Q8.8 degrees.
  function automatic logic [ZW-1:0] cordic_atan(input logic [ItW-1:0] it);
    logic [ZW-1:0] r;
    unique case (it)
      4'd0:    r = 17'd11520;
      4'd1:    r = 17'd6801;
      4'd2:    r = 17'd3593;
      4'd3:    r = 17'd1824;
      4'd4:    r = 17'd916;
      4'd5:    r = 17'd458;
      4'd6:    r = 17'd229;
      4'd7:    r = 17'd115;
      4'd8:    r = 17'd57;
      4'd9:    r = 17'd29;
      4'd10:   r = 17'd14;
      4'd11:   r = 17'd7;
      4'd12:   r = 17'd4;
      4'd13:   r = 17'd2;
      4'd14:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/lbpm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lbpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/lbpm_front.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher front end
// Accepts bar requests and works out the tilt angle with an iterative CORDIC.
// ----------------------------------------------------------------------------
module lbpm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lbpm_pkg::coord_t  center_x_i,
  input  lbpm_pkg::coord_t  center_y_i,
  input  lbpm_pkg::coord_t  top_x_i,
  input  lbpm_pkg::coord_t  top_y_i,
  input  lbpm_pkg::coord_t  bottom_x_i,
  input  lbpm_pkg::coord_t  bottom_y_i,
  input  lbpm_pkg::coord_t  bar_length_i,
  input  logic              last_bar_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output lbpm_pkg::bar_rec_t rec_o
);
  import lbpm_pkg::*;

  front_state_e state_q, state_d;

  logic signed [CordicW-1:0] x_q, y_q, sx, sy;
  logic signed [ZW-1:0]      z_q, z_clamp;
  logic [ItW-1:0]            it_q;
  logic                      neg_q;
  bar_rec_t                  rec_q;

  logic signed [CoordW:0] dx, dy;
  logic [CoordW-1:0]      adx, ady;
  logic                   accept, special;

  assign accept  = in_valid_i && (state_q == F_IDLE);
  assign dx      = $signed({1'b0, top_x_i}) - $signed({1'b0, bottom_x_i});
  assign dy      = $signed({1'b0, bottom_y_i}) - $signed({1'b0, top_y_i});
  assign adx     = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
  assign ady     = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
  assign special = (dy == '0) || (dx == '0);
  assign sx      = x_q >>> it_q;
  assign sy      = y_q >>> it_q;

  always_comb begin
    if (z_q < 0) begin
      z_clamp = '0;
    end else if (z_q > $signed({1'b0, AngRight})) begin
      z_clamp = $signed({1'b0, AngRight});
    end else begin
      z_clamp = z_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = special ? F_PUSH : F_ITER;
      F_ITER: if (it_q == ItW'(CordicIters - 1)) state_d = F_FIX;
      F_FIX:  state_d = F_PUSH;
      F_PUSH: if (push_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != F_IDLE);
    push_o     = (state_q == F_PUSH);
  end

  assign rec_o = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          rec_q.cx   <= center_x_i;
          rec_q.cy   <= center_y_i;
          rec_q.len  <= bar_length_i;
          rec_q.last <= last_bar_i;
          neg_q      <= dx[CoordW];
          x_q        <= $signed(CordicW'({adx, 4'b0}));
          y_q        <= $signed(CordicW'({ady, 4'b0}));
          z_q        <= '0;
          it_q       <= '0;
          if (dy == '0) begin
            rec_q.ang <= dx[CoordW] ? AngFlat : '0;
          end else begin
            rec_q.ang <= AngRight;
          end
        end
      end
      F_ITER: begin
        if (!y_q[CordicW-1]) begin
          x_q <= x_q + sy;
          y_q <= y_q - sx;
          z_q <= z_q + $signed(cordic_atan(it_q));
        end else begin
          x_q <= x_q - sy;
          y_q <= y_q + sx;
          z_q <= z_q - $signed(cordic_atan(it_q));
        end
        it_q <= it_q + 1'b1;
      end
      F_FIX: begin
        rec_q.ang <= neg_q ? AngFlat - AngW'(z_clamp) : AngW'(z_clamp);
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

FILE: sv/lbpm_queue.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher queue
// Two-entry queue of bar records between the front end and the matcher.
// ----------------------------------------------------------------------------
module lbpm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               push_ready_o,
  input  lbpm_pkg::bar_rec_t push_rec_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output lbpm_pkg::bar_rec_t pop_rec_o
);
  import lbpm_pkg::*;

  bar_rec_t   slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_rec_o    = slot_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      fill_q <= fill_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_rec_i;
    end
  end

endmodule

FILE: sv/lbpm_back.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher back end
// Stores the bars of a frame and walks the pairs greedily to emit matches.
// ----------------------------------------------------------------------------
module lbpm_back #(
  parameter int unsigned MaxBars = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_o,
  input  lbpm_pkg::bar_rec_t pop_rec_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbpm_pkg::idx_t     left_index_o,
  output lbpm_pkg::idx_t     right_index_o,
  output logic               pair_found_o,
  output logic               last_pair_o
);
  import lbpm_pkg::*;

  localparam int unsigned AW = (MaxBars > 1) ? $clog2(MaxBars) : 1;
  localparam int unsigned CW = $clog2(MaxBars + 1);

  back_state_e state_q, state_d;

  logic [CW-1:0]      cnt_q, i_q, j_q;
  logic [KW-1:0]      k_q;
  logic [MaxBars-1:0] used_q;
  bar_ent_t           bar_i_q, rdata;

  logic               ram_we;
  logic [AW-1:0]      raddr;
  bar_ent_t           wdata;

  logic [CoordW-1:0]  dx_q, hd_q;
  logic [CoordW:0]    s_q;
  logic [AngW:0]      am_q;
  logic [2*CoordW-1:0]   sqx_q, sqh_q;
  logic [2*CoordW+1:0]   s2_q;
  logic [31:0]           hlim_q;
  logic [29:0]           hprod_q;

  logic               out_v_q, out_found_q, out_last_q;
  idx_t               out_l_q, out_r_q;
  logic               pend_v_q;
  idx_t               pend_l_q, pend_r_q;

  logic [2*CoordW:0]  d2;
  logic               pair_ok, push_ok, can_store, i_done, cmp_wait;
  logic [AngW:0]      am_sum;
  logic               out_load;
  logic [MaxBars-1:0] pair_mask;

  assign wdata = '{cx: pop_rec_i.cx, cy: pop_rec_i.cy, len: pop_rec_i.len,
                   ang: pop_rec_i.ang};
  assign can_store = (cnt_q < CW'(MaxBars));

  lbpm_ram #(.Width(EntW), .Depth(MaxBars)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign d2      = (2*CoordW+1)'(sqx_q) + (2*CoordW+1)'(sqh_q);
  assign pair_ok = ((36'(d2) * 36'd16) >= (36'(s2_q) * 36'd49)) &&
                   (36'(d2) <= (36'(s2_q) * 36'd9)) &&
                   (32'(hprod_q) <= hlim_q);
  assign push_ok = !out_v_q || !out_stall_i;
  assign i_done  = (k_q == KW'(ResultLimit)) || (i_q >= cnt_q);
  assign cmp_wait = pair_ok && pend_v_q && !push_ok;
  assign am_sum  = (AngW+1)'(bar_i_q.ang) + (AngW+1)'(rdata.ang);

  // A new pair releases the one held back, which is then known not to be the
  // last one; the end of the walk releases the closing result.
  assign out_load  = ((state_q == B_CMP) && pair_ok && !cmp_wait && pend_v_q) ||
                     ((state_q == B_DONE) && push_ok);
  assign pair_mask = (MaxBars'(1) << i_q[AW-1:0]) | (MaxBars'(1) << j_q[AW-1:0]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_LOAD:    if (pop_valid_i && pop_rec_i.last) state_d = B_SCAN_I;
      B_SCAN_I: begin
        if (i_done) state_d = B_DONE;
        else if (!used_q[i_q[AW-1:0]]) state_d = B_LATCH_I;
      end
      B_LATCH_I: state_d = B_SCAN_J;
      B_SCAN_J: begin
        if (j_q >= cnt_q) state_d = B_SCAN_I;
        else if (!used_q[j_q[AW-1:0]]) state_d = B_DIFF;
      end
      B_DIFF:    state_d = B_MUL;
      B_MUL:     state_d = B_CMP;
      B_CMP: begin
        if (!pair_ok) state_d = B_SCAN_J;
        else if (!cmp_wait) state_d = B_SCAN_I;
      end
      B_DONE:    if (push_ok) state_d = B_LOAD;
      default:   state_d = B_LOAD;
    endcase
  end

  always_comb begin
    pop_o  = (state_q == B_LOAD);
    ram_we = (state_q == B_LOAD) && pop_valid_i && can_store;
    raddr  = (state_q == B_SCAN_I) ? i_q[AW-1:0] : j_q[AW-1:0];
  end

  assign out_valid_o   = out_v_q;
  assign left_index_o  = out_l_q;
  assign right_index_o = out_r_q;
  assign pair_found_o  = out_found_q;
  assign last_pair_o   = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_LOAD;
      cnt_q    <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      used_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        B_LOAD: begin
          if (pop_valid_i) begin
            if (can_store) cnt_q <= cnt_q + 1'b1;
            i_q      <= '0;
            k_q      <= '0;
            pend_v_q <= 1'b0;
          end
        end
        B_SCAN_I: begin
          if (!i_done) begin
            if (used_q[i_q[AW-1:0]]) i_q <= i_q + 1'b1;
            else j_q <= i_q + 1'b1;
          end
        end
        B_SCAN_J: begin
          if (j_q >= cnt_q) i_q <= i_q + 1'b1;
          else if (used_q[j_q[AW-1:0]]) j_q <= j_q + 1'b1;
        end
        B_CMP: begin
          if (!pair_ok) begin
            j_q <= j_q + 1'b1;
          end else if (!cmp_wait) begin
            pend_v_q <= 1'b1;
            used_q   <= used_q | pair_mask;
            k_q <= k_q + 1'b1;
            i_q <= i_q + 1'b1;
          end
        end
        B_DONE: begin
          if (push_ok) begin
            used_q  <= '0;
            cnt_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_LATCH_I: bar_i_q <= rdata;
      B_DIFF: begin
        dx_q <= (bar_i_q.cx > rdata.cx) ? bar_i_q.cx - rdata.cx : rdata.cx - bar_i_q.cx;
        hd_q <= (bar_i_q.cy > rdata.cy) ? bar_i_q.cy - rdata.cy : rdata.cy - bar_i_q.cy;
        s_q  <= (CoordW+1)'(bar_i_q.len) + (CoordW+1)'(rdata.len);
        am_q <= (am_sum > (AngW+1)'(AngClamp)) ? (AngW+1)'(AngClamp) : am_sum;
      end
      B_MUL: begin
        sqx_q   <= (2*CoordW)'(dx_q) * (2*CoordW)'(dx_q);
        sqh_q   <= (2*CoordW)'(hd_q) * (2*CoordW)'(hd_q);
        s2_q    <= (2*CoordW+2)'(s_q) * (2*CoordW+2)'(s_q);
        hlim_q  <= (32'(am_q) + 32'd76800) * 32'(s_q);
        hprod_q <= 30'(hd_q) * 30'd61440;
      end
      B_CMP: begin
        if (pair_ok && !cmp_wait) begin
          if (pend_v_q) begin
            out_l_q     <= pend_l_q;
            out_r_q     <= pend_r_q;
            out_found_q <= 1'b1;
            out_last_q  <= 1'b0;
          end
          pend_l_q <= IdxW'(i_q);
          pend_r_q <= IdxW'(j_q);
        end
      end
      B_DONE: begin
        if (push_ok) begin
          out_l_q     <= pend_v_q ? pend_l_q : '0;
          out_r_q     <= pend_v_q ? pend_r_q : '0;
          out_found_q <= pend_v_q;
          out_last_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/light_bar_pair_matcher.sv
// ----------------------------------------------------------------------------
// Light bar pair matcher
// Loads the light bars of one frame and emits the bar pairs that match.
// ----------------------------------------------------------------------------
// Each request carries one bar. The front end takes a bar and then works out
// its tilt angle (fifteen CORDIC iterations of one shared shift-add unit, a
// clamp step and a hand-over); it takes no new bar until it has handed the
// previous one over, and a level or upright bar skips the iterations and the
// clamp. A two-entry queue lets the front end keep loading while the
// matcher is busy or its output is stalled. After the bar marked last, the
// matcher walks all pairs i<j greedily: a skipped first bar takes one scan
// step, a first bar is read by a scan and a latch step, and each pair test
// steps through store read, differences, products and compare. Results
// leave through an output register; one pair is held back until the next is
// found or the walk ends, so that the final result of the frame carries
// last_pair. A frame without a pair yields one result with pair_found low.
// Bars beyond MaxBars are dropped but their last mark still ends the frame;
// at most sixteen pairs are reported.
// ----------------------------------------------------------------------------
module light_bar_pair_matcher #(
  parameter int unsigned MaxBars = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lbpm_pkg::coord_t center_x_i,
  input  lbpm_pkg::coord_t center_y_i,
  input  lbpm_pkg::coord_t top_x_i,
  input  lbpm_pkg::coord_t top_y_i,
  input  lbpm_pkg::coord_t bottom_x_i,
  input  lbpm_pkg::coord_t bottom_y_i,
  input  lbpm_pkg::coord_t bar_length_i,
  input  logic             last_bar_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lbpm_pkg::idx_t   left_index_o,
  output lbpm_pkg::idx_t   right_index_o,
  output logic             pair_found_o,
  output logic             last_pair_o
);
  import lbpm_pkg::*;

`include "light_bar_pair_matcher_macros.svh"

  logic     push, push_ready, pop_valid, pop;
  bar_rec_t push_rec, pop_rec;

  // Front end: request intake and angle computation.
  lbpm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .top_x_i      (top_x_i),
    .top_y_i      (top_y_i),
    .bottom_x_i   (bottom_x_i),
    .bottom_y_i   (bottom_y_i),
    .bar_length_i (bar_length_i),
    .last_bar_i   (last_bar_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .rec_o        (push_rec)
  );

  // Decoupling queue between angle computation and matching.
  lbpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_rec_o    (pop_rec)
  );

  // Back end: bar store, pair walk and result register.
  lbpm_back #(.MaxBars(MaxBars)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pop_rec_i     (pop_rec),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_index_o  (left_index_o),
    .right_index_o (right_index_o),
    .pair_found_o  (pair_found_o),
    .last_pair_o   (last_pair_o)
  );

  // A result without a pair is always the closing result of its frame.
  `LBPM_ASSERT_SAME(a_nopair_last, clk_i, rst_ni, out_valid_o && !pair_found_o, last_pair_o, "no-pair result not marked last")
  // The no-pair result carries zero indices.
  `LBPM_ASSERT_SAME(a_nopair_zero, clk_i, rst_ni, out_valid_o && !pair_found_o, (left_index_o == '0) && (right_index_o == '0), "no-pair result has indices")
  // Once a bar is taken the front end is busy with it in the next cycle.
  `LBPM_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "front end free right after a request")
  // A reported pair always names the lower index first.
  `LBPM_ASSERT_SAME(a_pair_order, clk_i, rst_ni, out_valid_o && pair_found_o && (MaxBars <= 32), left_index_o < right_index_o, "pair indices out of order")

endmodule
